// ----- hw/rtl/sbd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and command encodings for the streaming Barrett
// divisibility core. No dependencies; used by every other file in hw/rtl.
package sbd_pkg;

    localparam int WORD_W             = 32;
    localparam int DWORD_W            = 2 * WORD_W;
    localparam int CHUNK_BITS_DEFAULT = 32;
    localparam int RECIP_STEPS        = DWORD_W;
    localparam int RCNT_W             = $clog2(RECIP_STEPS);

    // One input beat: a chunk of the magnitude and its framing flags.
    typedef struct packed {
        logic [WORD_W-1:0] chunk_value;
        logic              first_chunk;
        logic              last_chunk;
    } chunk_item_t;

    // One output beat.
    typedef struct packed {
        logic [WORD_W-1:0] remainder;
        logic              divisible;
    } result_item_t;

    // Operand pair presented to the shared 32 x 32 multiplier.
    typedef enum logic [2:0] {
        MS_X0R0 = 3'd0,
        MS_X0R1 = 3'd1,
        MS_X1R0 = 3'd2,
        MS_X1R1 = 3'd3,
        MS_Q0D  = 3'd4,
        MS_Q1D  = 3'd5
    } mul_sel_t;

    // What the datapath does with the registered partial product.
    typedef enum logic [2:0] {
        ACC_NONE   = 3'd0,
        ACC_INIT   = 3'd1,
        ACC_ADD    = 3'd2,
        ACC_QUOT   = 3'd3,
        ACC_SUB_LO = 3'd4,
        ACC_SUB_HI = 3'd5
    } acc_op_t;

    typedef struct packed {
        logic     load_x;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     corr_sub;
        logic     commit;
        logic     out_load;
        logic     cfg_load;
        logic     recip_step;
    } dp_cmd_t;

    typedef struct packed {
        logic r_ge_d;
        logic last;
        logic cfg_nonzero;
    } dp_status_t;

endpackage

// ----- hw/rtl/sbd_ctrl.sv -----
`timescale 1ns / 1ps
// Controller for the streaming Barrett divisibility core: sequences the
// reciprocal division, the multiply schedule and the output register.
// Depends on sbd_pkg.
module sbd_ctrl import sbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_RECIP = 11'b000_0000_0010,
        S_M00   = 11'b000_0000_0100,
        S_M01   = 11'b000_0000_1000,
        S_M10   = 11'b000_0001_0000,
        S_M11   = 11'b000_0010_0000,
        S_QUOT  = 11'b000_0100_0000,
        S_MQ0   = 11'b000_1000_0000,
        S_MQ1   = 11'b001_0000_0000,
        S_SUBH  = 11'b010_0000_0000,
        S_CORR  = 11'b100_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [RCNT_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = (state_reg == S_IDLE);
    // A pending configuration beat takes precedence over a chunk.
    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel = MS_X0R0;
        cmd.acc_op  = ACC_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    // A zero divisor is accepted and dropped.
                    if (status.cfg_nonzero)
                    begin
                        cmd.cfg_load = 1'b1;
                        cnt_next     = '0;
                        state_next   = S_RECIP;
                    end
                end
                else if (in_valid)
                begin
                    cmd.load_x = 1'b1;
                    state_next = S_M00;
                end
            end
            S_RECIP:
            begin
                cmd.recip_step = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == RCNT_W'(RECIP_STEPS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_M00:
            begin
                cmd.mul_sel = MS_X0R0;
                state_next  = S_M01;
            end
            S_M01:
            begin
                cmd.mul_sel = MS_X0R1;
                cmd.acc_op  = ACC_INIT;
                state_next  = S_M10;
            end
            S_M10:
            begin
                cmd.mul_sel = MS_X1R0;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_M11;
            end
            S_M11:
            begin
                cmd.mul_sel = MS_X1R1;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_QUOT;
            end
            S_QUOT:
            begin
                cmd.acc_op = ACC_QUOT;
                state_next = S_MQ0;
            end
            S_MQ0:
            begin
                cmd.mul_sel = MS_Q0D;
                state_next  = S_MQ1;
            end
            S_MQ1:
            begin
                cmd.mul_sel = MS_Q1D;
                cmd.acc_op  = ACC_SUB_LO;
                state_next  = S_SUBH;
            end
            S_SUBH:
            begin
                cmd.acc_op = ACC_SUB_HI;
                state_next = S_CORR;
            end
            S_CORR:
            begin
                if (status.r_ge_d)
                begin
                    cmd.corr_sub = 1'b1;
                end
                else if (!status.last || out_free)
                begin
                    cmd.commit   = 1'b1;
                    cmd.out_load = status.last;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The reciprocal division always ends after its last step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RECIP && cnt_reg == RCNT_W'(RECIP_STEPS - 1)) |=> (state_reg == S_IDLE))
        else $error("reciprocal division did not finish on time");

    // A new result never overwrites one that the receiver has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while full");

    // Only a final chunk produces an output beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && out_valid_next) |-> (state_reg == S_CORR && status.last))
        else $error("output beat raised outside the final chunk");

endmodule

// ----- hw/rtl/sbd_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the streaming Barrett divisibility core: divisor, reciprocal,
// running remainder, the shared 32 x 32 multiplier and the result register.
// Depends on sbd_pkg.
module sbd_datapath import sbd_pkg::*;
#(
    parameter int CHUNK_BITS = CHUNK_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  chunk_item_t       in_item,
    input  logic [WORD_W-1:0] cfg_data,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    output result_item_t      out_item
);

    localparam logic [WORD_W-1:0] CHUNK_MASK =
        WORD_W'((DWORD_W'(1) << CHUNK_BITS) - DWORD_W'(1));

    logic [WORD_W-1:0]  divisor_reg;
    logic [DWORD_W-1:0] recip_reg;
    logic [WORD_W-1:0]  drem_reg;
    logic [WORD_W-1:0]  rem_reg;
    logic [DWORD_W-1:0] x_reg;
    logic               last_reg;
    logic [DWORD_W-1:0] pp_reg;
    logic [DWORD_W+1:0] acc_reg;
    logic [DWORD_W-1:0] q_reg;
    logic [DWORD_W-1:0] r_reg;
    result_item_t       out_reg;

    logic [WORD_W-1:0]  rem_src;
    logic [DWORD_W-1:0] x_next;
    logic [WORD_W-1:0]  mul_a;
    logic [WORD_W-1:0]  mul_b;
    logic [WORD_W:0]    dtrial;
    logic               dge;

    // A first chunk starts a new number from a zero remainder.
    assign rem_src = in_item.first_chunk ? '0 : rem_reg;
    assign x_next  = (DWORD_W'(rem_src) << CHUNK_BITS)
                   | DWORD_W'(in_item.chunk_value & CHUNK_MASK);

    always_comb
    begin
        mul_a = x_reg[WORD_W-1:0];
        mul_b = recip_reg[WORD_W-1:0];
        unique case (cmd.mul_sel)
            MS_X0R0:
            begin
                mul_a = x_reg[WORD_W-1:0];
                mul_b = recip_reg[WORD_W-1:0];
            end
            MS_X0R1:
            begin
                mul_a = x_reg[WORD_W-1:0];
                mul_b = recip_reg[DWORD_W-1:WORD_W];
            end
            MS_X1R0:
            begin
                mul_a = x_reg[DWORD_W-1:WORD_W];
                mul_b = recip_reg[WORD_W-1:0];
            end
            MS_X1R1:
            begin
                mul_a = x_reg[DWORD_W-1:WORD_W];
                mul_b = recip_reg[DWORD_W-1:WORD_W];
            end
            MS_Q0D:
            begin
                mul_a = q_reg[WORD_W-1:0];
                mul_b = divisor_reg;
            end
            MS_Q1D:
            begin
                mul_a = q_reg[DWORD_W-1:WORD_W];
                mul_b = divisor_reg;
            end
            default:
            begin
                mul_a = x_reg[WORD_W-1:0];
                mul_b = recip_reg[WORD_W-1:0];
            end
        endcase
    end

    // Restoring division of an all-ones dividend: every shifted-in bit is one.
    assign dtrial = {drem_reg, 1'b1};
    assign dge    = dtrial >= {1'b0, divisor_reg};

    assign status.r_ge_d      = r_reg >= DWORD_W'(divisor_reg);
    assign status.last        = last_reg;
    assign status.cfg_nonzero = (cfg_data != '0);
    assign out_item           = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= WORD_W'(1);
            recip_reg   <= '1;
            rem_reg     <= '0;
        end
        else
        begin
            if (cmd.cfg_load)
            begin
                divisor_reg <= cfg_data;
            end
            if (cmd.recip_step)
            begin
                recip_reg <= {recip_reg[DWORD_W-2:0], dge};
            end
            if (cmd.commit)
            begin
                rem_reg <= r_reg[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg <= DWORD_W'(mul_a) * DWORD_W'(mul_b);
        if (cmd.cfg_load)
        begin
            drem_reg <= '0;
        end
        else if (cmd.recip_step)
        begin
            drem_reg <= dge ? WORD_W'(dtrial - {1'b0, divisor_reg}) : dtrial[WORD_W-1:0];
        end
        if (cmd.load_x)
        begin
            x_reg    <= x_next;
            last_reg <= in_item.last_chunk;
        end
        // High half of x * reciprocal, gathered one partial product at a time.
        case (cmd.acc_op)
            ACC_INIT:   acc_reg <= (DWORD_W + 2)'(pp_reg[DWORD_W-1:WORD_W]);
            ACC_ADD:    acc_reg <= acc_reg + (DWORD_W + 2)'(pp_reg);
            ACC_QUOT:   q_reg   <= pp_reg + DWORD_W'(acc_reg[DWORD_W+1:WORD_W]);
            ACC_SUB_LO: r_reg   <= x_reg - pp_reg;
            ACC_SUB_HI: r_reg   <= r_reg - {pp_reg[WORD_W-1:0], {WORD_W{1'b0}}};
            default:
            begin
                if (cmd.corr_sub)
                begin
                    r_reg <= r_reg - DWORD_W'(divisor_reg);
                end
            end
        endcase
        if (cmd.out_load)
        begin
            out_reg.remainder <= r_reg[WORD_W-1:0];
            out_reg.divisible <= (r_reg == '0);
        end
    end

    // The divisor can never become zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        divisor_reg != '0)
        else $error("divisor register holds zero");

    // A committed remainder is fully reduced.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (rem_reg < divisor_reg))
        else $error("running remainder not below the divisor");

    // The divisible flag agrees with the remainder it travels with.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (out_reg.divisible == (out_reg.remainder == '0)))
        else $error("divisible flag disagrees with remainder");

endmodule

// ----- hw/rtl/streaming_barrett_divisibility_core.sv -----
`timescale 1ns / 1ps
// Top level of the streaming Barrett divisibility core: instantiates the
// controller and the datapath. Depends on sbd_pkg, sbd_ctrl, sbd_datapath.
//
// Usage. A long unsigned number enters on the in channel as 32-bit chunks,
// most significant first; first_chunk starts a new number from a zero
// remainder and last_chunk marks its final chunk. Each beat on the in
// channel is taken when in_valid is high and in_stall low. After the last
// chunk one beat leaves on the out channel with the remainder modulo the
// divisor and a divisible flag, under the same valid/stall rule.
// A chunk occupies the block from acceptance until it is back in idle, and no
// new chunk is taken meanwhile: six products go through the one shared
// 32 x 32 multiplier, with a register after each, then up to two correction
// subtractions. The result of a final chunk enters the output register once
// its corrections are done and that register is free. The divisor is
// written on the cfg channel while the block is idle; a nonzero write
// starts a bit-serial division for the reciprocal, during which in_stall
// and not cfg_ready hold. A zero write is taken and ignored. Reset sets the
// divisor to one and the running remainder to zero. If the receiver stalls,
// the result waits in the output register; the next chunk is still taken and
// worked on, and only a further final chunk waits for the register to empty.
module streaming_barrett_divisibility_core import sbd_pkg::*;
#(
    parameter int CHUNK_BITS = CHUNK_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  chunk_item_t       in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output result_item_t      out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sbd_datapath #(
        .CHUNK_BITS (CHUNK_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );

endmodule
